// ----- rtl/core/ecp_pkg.sv -----
// Package for the EV charge pilot state machine: codes, payload structs and
// helper functions. No dependencies.
`default_nettype none

package ecp_pkg;

  localparam int unsigned PortsDefault = 2;
  localparam int unsigned DelayW       = 16;
  localparam int unsigned TimeW        = 32;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_QUIT_ERROR_DELAY    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ENTER_CHECK_DELAY   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELAY_CHECK_DELAY   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_VEHICLE_SWITCH_TMO  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DIODE_CHECK_ENABLE  = 3'd4;

  // Reset values of the configuration registers
  localparam logic [DelayW-1:0] QUIT_ERROR_DELAY_RST   = 16'd3000;
  localparam logic [DelayW-1:0] ENTER_CHECK_DELAY_RST  = 16'd500;
  localparam logic [DelayW-1:0] RELAY_CHECK_DELAY_RST  = 16'd100;
  localparam logic [DelayW-1:0] VEHICLE_SWITCH_TMO_RST = 16'd3000;

  // Pilot voltage levels
  localparam logic [1:0] LV_12V = 2'd0;
  localparam logic [1:0] LV_9V  = 2'd1;
  localparam logic [1:0] LV_6V  = 2'd2;

  // Check result codes
  localparam logic [1:0] CHK_IDLE    = 2'd0;
  localparam logic [1:0] CHK_SUCCESS = 2'd2;

  // Command codes
  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_ON   = 2'd1,
    CMD_OFF  = 2'd2
  } cmd_e;

  // Reported pilot state codes
  localparam logic [2:0] CODE_S0  = 3'd0;
  localparam logic [2:0] CODE_S1  = 3'd1;
  localparam logic [2:0] CODE_S1D = 3'd2;
  localparam logic [2:0] CODE_S2  = 3'd3;
  localparam logic [2:0] CODE_S2D = 3'd4;
  localparam logic [2:0] CODE_S3  = 3'd5;
  localparam logic [2:0] CODE_S3D = 3'd6;

  // Per-port pilot state, one-hot
  typedef enum logic [6:0] {
    ST_S0  = 7'b0000001,
    ST_S1  = 7'b0000010,
    ST_S1D = 7'b0000100,
    ST_S2  = 7'b0001000,
    ST_S2D = 7'b0010000,
    ST_S3  = 7'b0100000,
    ST_S3D = 7'b1000000
  } pilot_e;

  typedef struct packed {
    logic             port;
    logic [1:0]       cp_level;
    logic             error_present;
    logic [1:0]       short_check_result;
    logic [1:0]       diode_check_result;
    logic             relay_closed;
    logic             charge_request;
    logic [TimeW-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       out_port;
    logic [2:0] pilot_state;
    logic [1:0] pwm_cmd;
    logic [1:0] relay_cmd;
    logic [1:0] short_check_cmd;
    logic [1:0] diode_check_cmd;
  } out_item_t;

  typedef struct packed {
    logic [DelayW-1:0] quit_error_delay_ms;
    logic [DelayW-1:0] enter_check_delay_ms;
    logic [DelayW-1:0] relay_check_delay_ms;
    logic [DelayW-1:0] vehicle_switch_timeout_ms;
    logic              diode_check_enable;
  } cfg_t;

  function automatic logic [2:0] state_code(input pilot_e st);
    logic [2:0] code;
    code = CODE_S0;
    unique case (st)
      ST_S0:   code = CODE_S0;
      ST_S1:   code = CODE_S1;
      ST_S1D:  code = CODE_S1D;
      ST_S2:   code = CODE_S2;
      ST_S2D:  code = CODE_S2D;
      ST_S3:   code = CODE_S3;
      ST_S3D:  code = CODE_S3D;
      default: code = CODE_S0;
    endcase
    return code;
  endfunction

  // Wrapped time difference compared against a 16-bit delay
  function automatic logic elapsed(input logic [TimeW-1:0] now,
                                   input logic [TimeW-1:0] stamp,
                                   input logic [DelayW-1:0] delay);
    logic [TimeW-1:0] diff;
    diff = now - stamp;
    return diff >= {{(TimeW-DelayW){1'b0}}, delay};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ecp_stream_if.sv -----
// Valid/ready channel carrying one payload struct per transfer.
// Payload type is a parameter; used with ecp_pkg structs.
`default_nettype none

interface ecp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ev_charge_pilot_state_machine.sv -----
// Top level of the EV charge pilot state machine.
// Depends on ecp_pkg and ecp_stream_if.
`default_nettype none

// Each transfer on item_i is one scheduling pass for one charging port; it
// yields exactly one transfer on result_o with the port's new pilot state
// (S0, S1, S1', S2, S2', S3, S3') and the PWM, relay, short-check and
// diode-check commands. The block takes one item per cycle while the result
// register can drain: an item lands in the input register, and the per-port
// state lookup, the state machine step and the per-port state write happen
// as the item moves from there into the result register for result_o.
// Per-port state lives in flip-flops, so back-to-back items for the same port
// see each other's updates without stalls. The result register holds while
// the sink stalls; the input register keeps accepting as long as it can
// drain. Items for a port number at or above PORTS leave all state untouched
// and return state 0 with no commands. Configuration writes take effect on
// the next edge and should only be issued while no item is in flight.
module ev_charge_pilot_state_machine #(
  parameter int unsigned PORTS = ecp_pkg::PortsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  ecp_stream_if.sink                          item_i,
  ecp_stream_if.source                        result_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [ecp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [ecp_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam int unsigned IdxW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int unsigned TW   = ecp_pkg::TimeW;

  // Configuration registers
  ecp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quit_error_delay_ms       <= ecp_pkg::QUIT_ERROR_DELAY_RST;
      cfg_q.enter_check_delay_ms      <= ecp_pkg::ENTER_CHECK_DELAY_RST;
      cfg_q.relay_check_delay_ms      <= ecp_pkg::RELAY_CHECK_DELAY_RST;
      cfg_q.vehicle_switch_timeout_ms <= ecp_pkg::VEHICLE_SWITCH_TMO_RST;
      cfg_q.diode_check_enable        <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ecp_pkg::CFG_QUIT_ERROR_DELAY:   cfg_q.quit_error_delay_ms <= cfg_wdata_i;
        ecp_pkg::CFG_ENTER_CHECK_DELAY:  cfg_q.enter_check_delay_ms <= cfg_wdata_i;
        ecp_pkg::CFG_RELAY_CHECK_DELAY:  cfg_q.relay_check_delay_ms <= cfg_wdata_i;
        ecp_pkg::CFG_VEHICLE_SWITCH_TMO: cfg_q.vehicle_switch_timeout_ms <= cfg_wdata_i;
        ecp_pkg::CFG_DIODE_CHECK_ENABLE: cfg_q.diode_check_enable <= cfg_wdata_i[0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Input register and result register with their handshakes
  logic               in_vld_q;
  ecp_pkg::in_item_t  in_q;
  logic               out_vld_q;
  ecp_pkg::out_item_t out_q;
  logic               adv;

  // Move the held item into the result register when that slot frees up
  assign adv            = in_vld_q && (!out_vld_q || result_o.ready);
  assign item_i.ready   = !in_vld_q || adv;
  assign result_o.valid = out_vld_q;
  assign result_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (item_i.ready) begin
      in_vld_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_q <= item_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Per-port state
  ecp_pkg::pilot_e   mode_q        [PORTS];
  logic [TW-1:0]     err_stamp_q   [PORTS];
  logic [TW-1:0]     chk_stamp_q   [PORTS];
  logic [TW-1:0]     rly_stamp_q   [PORTS];
  logic              rly_armed_q   [PORTS];
  logic [TW-1:0]     veh_stamp_q   [PORTS];
  logic [1:0]        short_held_q  [PORTS];
  logic [1:0]        diode_held_q  [PORTS];

  logic [IdxW-1:0] idx;
  logic            in_range;

  assign idx      = IdxW'(in_q.port);
  assign in_range = {{(TW-1){1'b0}}, in_q.port} < TW'(PORTS);

  // Next-state values for the addressed port
  ecp_pkg::pilot_e mode_d;
  ecp_pkg::pilot_e mode_cur;
  logic [TW-1:0]   err_stamp_d;
  logic [TW-1:0]   chk_stamp_d;
  logic [TW-1:0]   rly_stamp_d;
  logic            rly_armed_d;
  logic [TW-1:0]   veh_stamp_d;
  logic [1:0]      short_held_d;
  logic [1:0]      diode_held_d;
  ecp_pkg::cmd_e   pwm_cmd;
  ecp_pkg::cmd_e   relay_cmd;
  ecp_pkg::cmd_e   sc_cmd;
  ecp_pkg::cmd_e   dc_cmd;
  logic            vehicle;
  logic            charge;
  logic [1:0]      lv;
  logic [TW-1:0]   now;
  ecp_pkg::out_item_t result_d;

  always_comb begin
    lv      = in_q.cp_level;
    now     = in_q.now_ms;
    charge  = in_q.charge_request;
    vehicle = (lv == ecp_pkg::LV_9V) || (lv == ecp_pkg::LV_6V);

    mode_cur     = mode_q[idx];
    err_stamp_d  = err_stamp_q[idx];
    chk_stamp_d  = chk_stamp_q[idx];
    rly_stamp_d  = rly_stamp_q[idx];
    rly_armed_d  = rly_armed_q[idx];
    veh_stamp_d  = veh_stamp_q[idx];
    short_held_d = short_held_q[idx];
    diode_held_d = diode_held_q[idx];
    pwm_cmd      = ecp_pkg::CMD_NONE;
    relay_cmd    = ecp_pkg::CMD_NONE;
    sc_cmd       = ecp_pkg::CMD_NONE;
    dc_cmd       = ecp_pkg::CMD_NONE;

    // An error outside S0 drops everything and forces S0
    if (mode_cur != ecp_pkg::ST_S0 && in_q.error_present) begin
      sc_cmd      = ecp_pkg::CMD_OFF;
      dc_cmd      = ecp_pkg::CMD_OFF;
      pwm_cmd     = ecp_pkg::CMD_OFF;
      relay_cmd   = ecp_pkg::CMD_OFF;
      err_stamp_d = now;
      mode_cur    = ecp_pkg::ST_S0;
    end

    mode_d = mode_cur;

    unique case (mode_cur)
      ecp_pkg::ST_S0: begin
        if (in_q.error_present) begin
          err_stamp_d = now;
        end
        if (ecp_pkg::elapsed(now, err_stamp_d, cfg_q.quit_error_delay_ms)) begin
          mode_d = ecp_pkg::ST_S1;
        end
      end
      ecp_pkg::ST_S1: begin
        if (vehicle) begin
          short_held_d = ecp_pkg::CHK_IDLE;
          chk_stamp_d  = now;
          mode_d       = ecp_pkg::ST_S2;
          if (cfg_q.diode_check_enable) begin
            dc_cmd = ecp_pkg::CMD_ON;
          end else begin
            diode_held_d = ecp_pkg::CHK_SUCCESS;
          end
        end
      end
      ecp_pkg::ST_S1D: begin
        if (vehicle) begin
          rly_armed_d = 1'b0;
          mode_d      = ecp_pkg::ST_S2D;
        end else begin
          mode_d  = ecp_pkg::ST_S1;
          pwm_cmd = ecp_pkg::CMD_OFF;
        end
      end
      ecp_pkg::ST_S2: begin
        // Start the short check once the entry delay has run out
        if (ecp_pkg::elapsed(now, chk_stamp_d, cfg_q.enter_check_delay_ms)) begin
          if (short_held_d == ecp_pkg::CHK_IDLE) begin
            sc_cmd = ecp_pkg::CMD_ON;
          end
          short_held_d = in_q.short_check_result;
        end
        if (vehicle) begin
          if (cfg_q.diode_check_enable) begin
            diode_held_d = in_q.diode_check_result;
          end
          if (short_held_d == ecp_pkg::CHK_SUCCESS &&
              diode_held_d == ecp_pkg::CHK_SUCCESS && charge) begin
            pwm_cmd     = ecp_pkg::CMD_ON;
            mode_d      = ecp_pkg::ST_S2D;
            rly_armed_d = 1'b0;
          end
        end else if (lv == ecp_pkg::LV_12V) begin
          mode_d = ecp_pkg::ST_S1;
          dc_cmd = ecp_pkg::CMD_OFF;
          sc_cmd = ecp_pkg::CMD_OFF;
        end
      end
      ecp_pkg::ST_S2D: begin
        if (charge) begin
          if (lv == ecp_pkg::LV_6V) begin
            // Close the relay once, then wait before trusting its feedback
            if (!rly_armed_d) begin
              relay_cmd   = ecp_pkg::CMD_ON;
              rly_stamp_d = now;
              rly_armed_d = 1'b1;
            end
            if (ecp_pkg::elapsed(now, rly_stamp_d, cfg_q.relay_check_delay_ms) &&
                in_q.relay_closed) begin
              mode_d = ecp_pkg::ST_S3D;
            end
          end else if (lv == ecp_pkg::LV_9V) begin
            relay_cmd   = ecp_pkg::CMD_OFF;
            rly_armed_d = 1'b0;
          end else if (lv == ecp_pkg::LV_12V) begin
            relay_cmd = ecp_pkg::CMD_OFF;
            mode_d    = ecp_pkg::ST_S1D;
          end
        end else begin
          // Stop request wins: drop PWM and relay, restart the check delay
          pwm_cmd      = ecp_pkg::CMD_OFF;
          relay_cmd    = ecp_pkg::CMD_OFF;
          short_held_d = ecp_pkg::CHK_IDLE;
          chk_stamp_d  = now;
          mode_d       = ecp_pkg::ST_S2;
        end
      end
      ecp_pkg::ST_S3: begin
        if (lv == ecp_pkg::LV_12V) begin
          relay_cmd = ecp_pkg::CMD_OFF;
          mode_d    = ecp_pkg::ST_S1;
        end else if (lv == ecp_pkg::LV_9V ||
                     ecp_pkg::elapsed(now, veh_stamp_d,
                                      cfg_q.vehicle_switch_timeout_ms)) begin
          relay_cmd    = ecp_pkg::CMD_OFF;
          short_held_d = ecp_pkg::CHK_IDLE;
          chk_stamp_d  = now;
          mode_d       = ecp_pkg::ST_S2;
        end
      end
      ecp_pkg::ST_S3D: begin
        if (lv == ecp_pkg::LV_9V) begin
          relay_cmd   = ecp_pkg::CMD_OFF;
          mode_d      = ecp_pkg::ST_S2D;
          rly_armed_d = 1'b0;
        end else if (lv == ecp_pkg::LV_12V) begin
          relay_cmd = ecp_pkg::CMD_OFF;
          mode_d    = ecp_pkg::ST_S1D;
        end else if (!charge) begin
          pwm_cmd     = ecp_pkg::CMD_OFF;
          mode_d      = ecp_pkg::ST_S3;
          veh_stamp_d = now;
        end
      end
      default: ;
    endcase

    result_d.out_port = in_q.port;
    if (in_range) begin
      result_d.pilot_state     = ecp_pkg::state_code(mode_d);
      result_d.pwm_cmd         = pwm_cmd;
      result_d.relay_cmd       = relay_cmd;
      result_d.short_check_cmd = sc_cmd;
      result_d.diode_check_cmd = dc_cmd;
    end else begin
      result_d.pilot_state     = ecp_pkg::CODE_S0;
      result_d.pwm_cmd         = ecp_pkg::CMD_NONE;
      result_d.relay_cmd       = ecp_pkg::CMD_NONE;
      result_d.short_check_cmd = ecp_pkg::CMD_NONE;
      result_d.diode_check_cmd = ecp_pkg::CMD_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= result_d;
    end
  end

  // Commit the step to the addressed port as the item advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PORTS; i++) begin
        mode_q[i]       <= ecp_pkg::ST_S0;
        err_stamp_q[i]  <= '0;
        chk_stamp_q[i]  <= '0;
        rly_stamp_q[i]  <= '0;
        rly_armed_q[i]  <= 1'b0;
        veh_stamp_q[i]  <= '0;
        short_held_q[i] <= ecp_pkg::CHK_IDLE;
        diode_held_q[i] <= ecp_pkg::CHK_IDLE;
      end
    end else if (adv && in_range) begin
      mode_q[idx]       <= mode_d;
      err_stamp_q[idx]  <= err_stamp_d;
      chk_stamp_q[idx]  <= chk_stamp_d;
      rly_stamp_q[idx]  <= rly_stamp_d;
      rly_armed_q[idx]  <= rly_armed_d;
      veh_stamp_q[idx]  <= veh_stamp_d;
      short_held_q[idx] <= short_held_d;
      diode_held_q[idx] <= diode_held_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ecp_checker.sv -----
// Port-level checks for the EV charge pilot state machine, bound to the top.
// Depends on ecp_pkg.
`default_nettype none

module ecp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire ecp_pkg::out_item_t res_data
);

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // PWM start only on the way into S2'
  a_pwm_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_data.pwm_cmd == ecp_pkg::CMD_ON
      |-> res_data.pilot_state == ecp_pkg::CODE_S2D)
    else $error("PWM start outside S2'");

  // Relay close only while in S2' or when reaching S3'
  a_relay_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_data.relay_cmd == ecp_pkg::CMD_ON
      |-> res_data.pilot_state == ecp_pkg::CODE_S2D ||
          res_data.pilot_state == ecp_pkg::CODE_S3D)
    else $error("relay close outside S2'/S3'");

  // Diode check start only on entry to S2
  a_diode_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_data.diode_check_cmd == ecp_pkg::CMD_ON
      |-> res_data.pilot_state == ecp_pkg::CODE_S2)
    else $error("diode check start outside S2 entry");

endmodule

bind ev_charge_pilot_state_machine ecp_checker u_ecp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (result_o.valid),
  .res_ready (result_o.ready),
  .res_data  (result_o.data)
);

`default_nettype wire
